FILE: hw/rtl/scga_pkg.sv
package scga_pkg;

    // Field widths of the item and result.
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 13;
    localparam int MAG_W  = 12;

    // Fraction bits of the angle result, in fractions of a degree.
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ANGLE_W         = 9 + ANGLE_FRAC_BITS;

    // Scharr weights of the outer and center taps.
    localparam logic signed [GRAD_W-1:0] SCHARR_OUTER  = GRAD_W'(3);
    localparam logic signed [GRAD_W-1:0] SCHARR_CENTER = GRAD_W'(10);

    // Rotation datapath: vector scaled by 2^CORDIC_FRAC, one micro-rotation per stage.
    localparam int CORDIC_STEPS = 58;
    localparam int CORDIC_FRAC  = 48;
    localparam int XY_W         = 62;

    // Angle accumulator in degrees with Z_FRAC fraction bits.
    localparam int Z_FRAC = 54;
    localparam int Z_W    = 62;

    // Full direction word, 0 up to 360 degrees, and the shift down to the result.
    localparam int ANGLE_SHIFT = Z_FRAC - ANGLE_FRAC_BITS;
    localparam int T_W         = ANGLE_W + ANGLE_SHIFT;

    localparam logic [T_W-1:0] T_DEG45    = T_W'(45) << Z_FRAC;
    localparam logic [T_W-1:0] T_DEG90    = T_W'(90) << Z_FRAC;
    localparam logic [T_W-1:0] T_DEG180   = T_W'(180) << Z_FRAC;
    localparam logic [T_W-1:0] T_DEG360   = T_W'(360) << Z_FRAC;
    localparam logic [T_W-1:0] ROUND_HALF = T_W'(1) << (ANGLE_SHIFT - 1);

    localparam logic [ANGLE_W-1:0] FULL_TURN    = ANGLE_W'(360) << ANGLE_FRAC_BITS;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(90) << ANGLE_FRAC_BITS;

    // pi/4 in Q62, the same as pi in Q60.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // atan(2^-k) in radians, Q62, from the alternating arctangent series.
    function automatic logic [63:0] atan_rad_q62(input int unsigned k);
        logic [63:0] sum;
        logic [63:0] term;
        logic        neg;
        sum = '0;
        neg = 1'b0;
        if (k == 0)
        begin
            return PI_Q60;
        end
        for (int unsigned d = 1; k * d <= 62; d += 2)
        begin
            term = (64'd1 << (62 - k * d)) / 64'(d);
            if (neg)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
            neg = !neg;
        end
        return sum;
    endfunction

    // atan(2^-k) in degrees with Z_FRAC fraction bits:
    // rad_q62 * 180 / pi scaled by 2^(Z_FRAC - 62), with pi held as PI_Q60 / 2^60.
    function automatic logic [Z_W-1:0] atan_deg_step(input int unsigned k);
        logic [127:0] prod;
        prod = 128'(atan_rad_q62(k)) * 128'd180;
        prod = prod << (Z_FRAC - 2);
        return Z_W'(prod / 128'(PI_Q60));
    endfunction

endpackage

FILE: hw/rtl/scharr_gradient_angle_unit.sv
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   pix_nw pix_n pix_ne pix_w pix_e pix_sw pix_s pix_se
// out      out  out_valid / out_stall grad_x grad_y angle angle_valid
//
// One item enters per cycle unless in_stall holds it off.
// There are 63 register stages: the 58-step arctangent rotation chain, one step per stage,
// plus gradient, magnitude, octant, quadrant and rounding stages.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A result held by out_stall freezes the whole pipeline, and in_stall rises with it.
module scharr_gradient_angle_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [scga_pkg::PIX_W-1:0]             pix_nw,
    input  logic [scga_pkg::PIX_W-1:0]             pix_n,
    input  logic [scga_pkg::PIX_W-1:0]             pix_ne,
    input  logic [scga_pkg::PIX_W-1:0]             pix_w,
    input  logic [scga_pkg::PIX_W-1:0]             pix_e,
    input  logic [scga_pkg::PIX_W-1:0]             pix_sw,
    input  logic [scga_pkg::PIX_W-1:0]             pix_s,
    input  logic [scga_pkg::PIX_W-1:0]             pix_se,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [scga_pkg::GRAD_W-1:0]     grad_x,
    output logic signed [scga_pkg::GRAD_W-1:0]     grad_y,
    output logic [scga_pkg::ANGLE_W-1:0]           angle,
    output logic                                   angle_valid
);

    localparam int STEPS = scga_pkg::CORDIC_STEPS;

    // One stage of the rotation chain.
    typedef struct packed {
        logic signed [scga_pkg::XY_W-1:0]   x;
        logic signed [scga_pkg::XY_W-1:0]   y;
        logic signed [scga_pkg::Z_W-1:0]    z;
        logic signed [scga_pkg::GRAD_W-1:0] gx;
        logic signed [scga_pkg::GRAD_W-1:0] gy;
        logic                               swap;
        logic                               b_zero;
        logic                               b_eq;
    } cordic_t;

    // Pipeline advances unless a finished result is held at the output.
    logic adv;

    logic signed [scga_pkg::GRAD_W-1:0] p_nw, p_n, p_ne, p_w, p_e, p_sw, p_s, p_se;
    logic signed [scga_pkg::GRAD_W-1:0] gx_next, gy_next, gx_reg, gy_reg;
    logic                               grd_valid_reg;

    logic signed [scga_pkg::GRAD_W-1:0] abs_x, abs_y;
    logic [scga_pkg::MAG_W-1:0]         mag_x, mag_y, mag_a, mag_b;
    cordic_t                            prep_next;

    cordic_t                            cs_reg [STEPS+1];
    cordic_t                            step_next [STEPS];
    logic [STEPS:0]                     cs_valid_reg;

    logic signed [scga_pkg::Z_W-1:0]    z_fin;
    logic [scga_pkg::T_W-1:0]           oct;
    logic [scga_pkg::T_W-1:0]           alpha_next, alpha_reg;
    logic signed [scga_pkg::GRAD_W-1:0] alp_gx_reg, alp_gy_reg;
    logic                               alp_nz_next, alp_nz_reg;
    logic                               alp_valid_reg;

    logic [scga_pkg::T_W-1:0]           turn_next, turn_reg;
    logic signed [scga_pkg::GRAD_W-1:0] trn_gx_reg, trn_gy_reg;
    logic                               trn_nz_reg;
    logic                               trn_valid_reg;

    logic [scga_pkg::T_W-1:0]           rounded;
    logic [scga_pkg::ANGLE_W-1:0]       angle_full;
    logic [scga_pkg::ANGLE_W-1:0]       angle_next, angle_reg;
    logic signed [scga_pkg::GRAD_W-1:0] grad_x_reg, grad_y_reg;
    logic                               angle_valid_reg;
    logic                               out_valid_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Gradients: left minus right and bottom minus top with 3, 10, 3 weights.
    assign p_nw = scga_pkg::GRAD_W'(pix_nw);
    assign p_n  = scga_pkg::GRAD_W'(pix_n);
    assign p_ne = scga_pkg::GRAD_W'(pix_ne);
    assign p_w  = scga_pkg::GRAD_W'(pix_w);
    assign p_e  = scga_pkg::GRAD_W'(pix_e);
    assign p_sw = scga_pkg::GRAD_W'(pix_sw);
    assign p_s  = scga_pkg::GRAD_W'(pix_s);
    assign p_se = scga_pkg::GRAD_W'(pix_se);

    always_comb
    begin
        gx_next = scga_pkg::SCHARR_OUTER * (p_nw - p_ne + p_sw - p_se)
                + scga_pkg::SCHARR_CENTER * (p_w - p_e);
        gy_next = scga_pkg::SCHARR_OUTER * (p_sw + p_se - p_nw - p_ne)
                + scga_pkg::SCHARR_CENTER * (p_s - p_n);
    end

    // Magnitudes, octant fold and the starting vector of the rotation chain.
    always_comb
    begin
        abs_x = gx_reg[scga_pkg::GRAD_W-1] ? -gx_reg : gx_reg;
        abs_y = gy_reg[scga_pkg::GRAD_W-1] ? -gy_reg : gy_reg;
        mag_x = abs_x[scga_pkg::MAG_W-1:0];
        mag_y = abs_y[scga_pkg::MAG_W-1:0];
        prep_next.swap = mag_y > mag_x;
        mag_a = prep_next.swap ? mag_y : mag_x;
        mag_b = prep_next.swap ? mag_x : mag_y;
        prep_next.x      = scga_pkg::XY_W'({mag_a, {scga_pkg::CORDIC_FRAC{1'b0}}});
        prep_next.y      = scga_pkg::XY_W'({mag_b, {scga_pkg::CORDIC_FRAC{1'b0}}});
        prep_next.z      = '0;
        prep_next.gx     = gx_reg;
        prep_next.gy     = gy_reg;
        prep_next.b_zero = mag_b == '0;
        prep_next.b_eq   = mag_b == mag_a;
    end

    // Vectoring micro-rotations, one per stage; y is shifted rounding toward zero.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic signed [scga_pkg::XY_W-1:0] LOW_MASK =
            (scga_pkg::XY_W'(1) << k) - scga_pkg::XY_W'(1);
        localparam logic signed [scga_pkg::Z_W-1:0] STEP_ANG = scga_pkg::atan_deg_step(k);

        logic signed [scga_pkg::XY_W-1:0] xs;
        logic signed [scga_pkg::XY_W-1:0] ys_floor;
        logic                             ys_fix;

        always_comb
        begin
            xs       = cs_reg[k].x >>> k;
            ys_floor = cs_reg[k].y >>> k;
            ys_fix   = cs_reg[k].y[scga_pkg::XY_W-1] && ((cs_reg[k].y & LOW_MASK) != '0);
            step_next[k] = cs_reg[k];
            if (!cs_reg[k].y[scga_pkg::XY_W-1])
            begin
                step_next[k].x = cs_reg[k].x + ys_floor;
                step_next[k].y = cs_reg[k].y - xs;
                step_next[k].z = cs_reg[k].z + STEP_ANG;
            end
            else
            begin
                step_next[k].x = cs_reg[k].x - ys_floor - scga_pkg::XY_W'(ys_fix);
                step_next[k].y = cs_reg[k].y + xs;
                step_next[k].z = cs_reg[k].z - STEP_ANG;
            end
        end
    end

    // Octant angle, clamped to 0..45 degrees, with exact axis and diagonal cases.
    always_comb
    begin
        z_fin = cs_reg[STEPS].z;
        if (z_fin[scga_pkg::Z_W-1])
        begin
            oct = '0;
        end
        else if (scga_pkg::T_W'(z_fin) > scga_pkg::T_DEG45)
        begin
            oct = scga_pkg::T_DEG45;
        end
        else
        begin
            oct = scga_pkg::T_W'(z_fin);
        end
        if (cs_reg[STEPS].b_zero)
        begin
            oct = '0;
        end
        else if (cs_reg[STEPS].b_eq)
        begin
            oct = scga_pkg::T_DEG45;
        end
        alpha_next  = cs_reg[STEPS].swap ? scga_pkg::T_DEG90 - oct : oct;
        alp_nz_next = (cs_reg[STEPS].gx != '0) || (cs_reg[STEPS].gy != '0);
    end

    // Quadrant placement from the gradient signs.
    always_comb
    begin
        if (!alp_gy_reg[scga_pkg::GRAD_W-1])
        begin
            turn_next = alp_gx_reg[scga_pkg::GRAD_W-1] ? scga_pkg::T_DEG180 - alpha_reg
                                                       : alpha_reg;
        end
        else
        begin
            turn_next = alp_gx_reg[scga_pkg::GRAD_W-1] ? scga_pkg::T_DEG180 + alpha_reg
                                                       : scga_pkg::T_DEG360 - alpha_reg;
        end
    end

    // Round to the result precision; a full turn wraps to zero, and a zero gradient gives zero.
    always_comb
    begin
        rounded    = turn_reg + scga_pkg::ROUND_HALF;
        angle_full = rounded[scga_pkg::T_W-1:scga_pkg::ANGLE_SHIFT];
        if (!trn_nz_reg || angle_full >= scga_pkg::FULL_TURN)
        begin
            angle_next = '0;
        end
        else
        begin
            angle_next = angle_full;
        end
    end

    // Stage valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grd_valid_reg <= 1'b0;
            cs_valid_reg  <= '0;
            alp_valid_reg <= 1'b0;
            trn_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            grd_valid_reg <= in_valid;
            cs_valid_reg  <= {cs_valid_reg[STEPS-1:0], grd_valid_reg};
            alp_valid_reg <= cs_valid_reg[STEPS];
            trn_valid_reg <= alp_valid_reg;
            out_valid_reg <= trn_valid_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg    <= gx_next;
            gy_reg    <= gy_next;
            cs_reg[0] <= prep_next;
            for (int i = 0; i < STEPS; i++)
            begin
                cs_reg[i+1] <= step_next[i];
            end
            alpha_reg       <= alpha_next;
            alp_gx_reg      <= cs_reg[STEPS].gx;
            alp_gy_reg      <= cs_reg[STEPS].gy;
            alp_nz_reg      <= alp_nz_next;
            turn_reg        <= turn_next;
            trn_gx_reg      <= alp_gx_reg;
            trn_gy_reg      <= alp_gy_reg;
            trn_nz_reg      <= alp_nz_reg;
            angle_reg       <= angle_next;
            grad_x_reg      <= trn_gx_reg;
            grad_y_reg      <= trn_gy_reg;
            angle_valid_reg <= trn_nz_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign grad_x      = grad_x_reg;
    assign grad_y      = grad_y_reg;
    assign angle       = angle_reg;
    assign angle_valid = angle_valid_reg;

    // The direction flag agrees with the gradients that leave with it.
    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> angle_valid_reg == ((grad_x_reg != '0) || (grad_y_reg != '0)))
        else $error("angle_valid does not match the gradients");

    // The angle never reaches a full turn.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> angle_reg < scga_pkg::FULL_TURN)
        else $error("angle out of range");

    // A gradient in the first quadrant gives an angle of at most a quarter turn.
    a_first_quadrant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && grad_x_reg > 0 && grad_y_reg >= 0
        |-> angle_reg <= scga_pkg::QUARTER_TURN)
        else $error("first quadrant angle beyond a quarter turn");

    // The folded angle stays within a quarter turn.
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        alp_valid_reg |-> alpha_reg <= scga_pkg::T_DEG90)
        else $error("octant fold out of range");

    // A held result freezes the rotation chain, quadrant and output valid bits.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cs_valid_reg) && $stable(trn_valid_reg) && $stable(out_valid_reg))
        else $error("pipeline moved while the output was held");

endmodule

FILE: tb/tb_scharr_gradient_angle_unit.sv
module tb_scharr_gradient_angle_unit;

    // Fixed-point settings of the direction predictor.
    localparam logic [63:0] PI_FIXED  = 64'h3243F6A8885A308D;
    localparam int          DEG_Q     = 48;
    localparam int          ROT_STEPS = 58;

    // Run shape: idling stops after IDLE_END items, one long output hold.
    localparam int IDLE_END         = 330;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int RANDOM_WINDOWS   = 380;

    typedef struct packed {
        logic [scga_pkg::PIX_W-1:0] p_nw;
        logic [scga_pkg::PIX_W-1:0] p_n;
        logic [scga_pkg::PIX_W-1:0] p_ne;
        logic [scga_pkg::PIX_W-1:0] p_w;
        logic [scga_pkg::PIX_W-1:0] p_e;
        logic [scga_pkg::PIX_W-1:0] p_sw;
        logic [scga_pkg::PIX_W-1:0] p_s;
        logic [scga_pkg::PIX_W-1:0] p_se;
    } window_t;

    typedef struct packed {
        logic signed [scga_pkg::GRAD_W-1:0] gx;
        logic signed [scga_pkg::GRAD_W-1:0] gy;
        logic [scga_pkg::ANGLE_W-1:0]       ang;
        logic                               ok;
    } grad_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [scga_pkg::PIX_W-1:0]         pix_nw = '0;
    logic [scga_pkg::PIX_W-1:0]         pix_n = '0;
    logic [scga_pkg::PIX_W-1:0]         pix_ne = '0;
    logic [scga_pkg::PIX_W-1:0]         pix_w = '0;
    logic [scga_pkg::PIX_W-1:0]         pix_e = '0;
    logic [scga_pkg::PIX_W-1:0]         pix_sw = '0;
    logic [scga_pkg::PIX_W-1:0]         pix_s = '0;
    logic [scga_pkg::PIX_W-1:0]         pix_se = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [scga_pkg::GRAD_W-1:0] grad_x;
    logic signed [scga_pkg::GRAD_W-1:0] grad_y;
    logic [scga_pkg::ANGLE_W-1:0]       angle;
    logic                               angle_valid;

    window_t      pending_windows[$];
    grad_result_t expected_results[$];
    window_t      cur_win = '0;
    int           total_windows = 0;
    int           windows_sent = 0;
    int           results_seen = 0;
    int           fail_count = 0;
    int           send_gap = 0;
    int           hold_left = 0;
    bit           long_hold_done = 1'b0;
    int           directed_seen = 0;
    int           flat_seen = 0;
    logic [3:0]   quadrants_hit = '0;

    scharr_gradient_angle_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pix_nw      (pix_nw),
        .pix_n       (pix_n),
        .pix_ne      (pix_ne),
        .pix_w       (pix_w),
        .pix_e       (pix_e),
        .pix_sw      (pix_sw),
        .pix_s       (pix_s),
        .pix_se      (pix_se),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .angle       (angle),
        .angle_valid (angle_valid)
    );

    always #10 clk = ~clk;

    // Arctangent of 2^-k in radians, Q62, summed from the alternating series.
    function automatic logic [63:0] atan_rad_pow2(input int k);
        logic [63:0] acc;
        logic [63:0] term;
        bit          sub;
        acc = '0;
        sub = 1'b0;
        if (k == 0)
        begin
            return PI_FIXED;
        end
        for (int d = 1; k * d <= 62; d += 2)
        begin
            term = (64'd1 << (62 - k * d)) / 64'(d);
            if (sub)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
            sub = !sub;
        end
        return acc;
    endfunction

    // Right shift that rounds toward zero for negative values.
    function automatic longint shr_toward_zero(input longint v, input int k);
        if (v < 0)
        begin
            return -((-v) >> k);
        end
        return v >> k;
    endfunction

    // Direction of (a, b) in degrees, Q48, for 0 <= b <= a and a > 0.
    function automatic logic [63:0] octant_angle_q48(input logic [63:0] a,
                                                     input logic [63:0] b);
        longint       xr;
        longint       yr;
        longint       zr;
        longint       xs;
        longint       ys;
        longint       step;
        logic [63:0]  zu;
        logic [127:0] prod;
        if (b == 0)
        begin
            return 64'd0;
        end
        if (b == a)
        begin
            return 64'd45 << DEG_Q;
        end
        xr = longint'(a << DEG_Q);
        yr = longint'(b << DEG_Q);
        zr = 0;
        // Vectoring rotations drive y to zero and collect the angle in z.
        for (int k = 0; k < ROT_STEPS; k++)
        begin
            xs = shr_toward_zero(xr, k);
            ys = shr_toward_zero(yr, k);
            step = longint'(atan_rad_pow2(k));
            if (yr >= 0)
            begin
                xr = xr + ys;
                yr = yr - xs;
                zr = zr + step;
            end
            else
            begin
                xr = xr - ys;
                yr = yr + xs;
                zr = zr - step;
            end
        end
        if (zr < 0)
        begin
            zr = 0;
        end
        zu = 64'(zr);
        if (zu > PI_FIXED)
        begin
            zu = PI_FIXED;
        end
        // Radians Q62 to degrees Q48.
        prod = (128'(zu) * 128'd180) << 46;
        return 64'(prod / 128'(PI_FIXED));
    endfunction

    // Gradients and rounded direction of one window.
    function automatic grad_result_t scharr_predict(input window_t win);
        int           gxi;
        int           gyi;
        logic [63:0]  ax;
        logic [63:0]  ay;
        logic [63:0]  alpha;
        logic [63:0]  t;
        logic [63:0]  rounded;
        grad_result_t r;
        gxi = 3 * (int'(win.p_nw) - int'(win.p_ne) + int'(win.p_sw) - int'(win.p_se))
            + 10 * (int'(win.p_w) - int'(win.p_e));
        gyi = 3 * (int'(win.p_sw) + int'(win.p_se) - int'(win.p_nw) - int'(win.p_ne))
            + 10 * (int'(win.p_s) - int'(win.p_n));
        r.gx = scga_pkg::GRAD_W'(gxi);
        r.gy = scga_pkg::GRAD_W'(gyi);
        r.ang = '0;
        r.ok = 1'b0;
        if (gxi != 0 || gyi != 0)
        begin
            ax = 64'(gxi < 0 ? -gxi : gxi);
            ay = 64'(gyi < 0 ? -gyi : gyi);
            if (ay <= ax)
            begin
                alpha = octant_angle_q48(ax, ay);
            end
            else
            begin
                alpha = (64'd90 << DEG_Q) - octant_angle_q48(ay, ax);
            end
            // Unfold the first-quadrant angle by the signs of the gradients.
            if (gyi >= 0)
            begin
                t = (gxi >= 0) ? alpha : (64'd180 << DEG_Q) - alpha;
            end
            else
            begin
                t = (gxi < 0) ? (64'd180 << DEG_Q) + alpha : (64'd360 << DEG_Q) - alpha;
            end
            rounded = (t + (64'd1 << (DEG_Q - 1 - scga_pkg::ANGLE_FRAC_BITS)))
                      >> (DEG_Q - scga_pkg::ANGLE_FRAC_BITS);
            if (rounded >= (64'd360 << scga_pkg::ANGLE_FRAC_BITS))
            begin
                rounded = 64'd0;
            end
            r.ang = scga_pkg::ANGLE_W'(rounded);
            r.ok = 1'b1;
        end
        return r;
    endfunction

    task automatic queue_window(input int a, input int b, input int c, input int d,
                                input int e, input int f, input int g, input int h);
        pending_windows.push_back('{8'(a), 8'(b), 8'(c), 8'(d),
                                    8'(e), 8'(f), 8'(g), 8'(h)});
    endtask

    // Driver: presents pending windows, holds them while stalled, idles in bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(scharr_predict(cur_win));
                windows_sent++;
            end
            if (in_valid && in_stall)
            begin
                // The stalled item stays on the ports.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_windows.size() > 0)
            begin
                cur_win = pending_windows.pop_front();
                pix_nw <= cur_win.p_nw;
                pix_n <= cur_win.p_n;
                pix_ne <= cur_win.p_ne;
                pix_w <= cur_win.p_w;
                pix_e <= cur_win.p_e;
                pix_sw <= cur_win.p_sw;
                pix_s <= cur_win.p_s;
                pix_se <= cur_win.p_se;
                in_valid <= 1'b1;
                if (windows_sent < IDLE_END && (windows_sent / 48) % 3 != 2
                    && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(1, 10);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result against the oldest prediction and drives stall.
    always @(posedge clk)
    begin
        grad_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no window pending: grad_x=%0d grad_y=%0d angle=%0d",
                           grad_x, grad_y, angle);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (grad_x !== want.gx)
                    begin
                        $error("grad_x: expected %0d, got %0d", want.gx, grad_x);
                        fail_count++;
                    end
                    if (grad_y !== want.gy)
                    begin
                        $error("grad_y: expected %0d, got %0d", want.gy, grad_y);
                        fail_count++;
                    end
                    if (angle !== want.ang)
                    begin
                        $error("angle: expected %0d, got %0d", want.ang, angle);
                        fail_count++;
                    end
                    if (angle_valid !== want.ok)
                    begin
                        $error("angle_valid: expected %0d, got %0d", want.ok, angle_valid);
                        fail_count++;
                    end
                    if (want.ok)
                    begin
                        directed_seen++;
                        quadrants_hit[int'(want.ang) / int'(scga_pkg::QUARTER_TURN)] = 1'b1;
                    end
                    else
                    begin
                        flat_seen++;
                    end
                end
            end
            // One long hold lets the pipeline fill up and back-pressure the input.
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (results_seen < IDLE_END && (results_seen / 40) % 3 != 1
                     && $urandom_range(0, 6) == 0)
            begin
                hold_left = $urandom_range(1, 10) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int kind;
        int lo;
        int hi;
        int mid;
        int dx;
        int dy;
        int pos;
        int px [8];

        // Directed windows: flat, full-scale axes, diagonals, unit steps,
        // near-horizontal and near-vertical, a symmetric window and two alternating patterns.
        queue_window(0, 0, 0, 0, 0, 0, 0, 0);
        queue_window(255, 255, 255, 255, 255, 255, 255, 255);
        queue_window(255, 0, 0, 255, 0, 255, 0, 0);
        queue_window(0, 0, 255, 0, 255, 0, 0, 255);
        queue_window(0, 0, 0, 0, 0, 255, 255, 255);
        queue_window(255, 255, 255, 0, 0, 0, 0, 0);
        queue_window(0, 0, 0, 0, 0, 255, 0, 0);
        queue_window(0, 0, 0, 0, 0, 0, 0, 255);
        queue_window(255, 0, 0, 0, 0, 0, 0, 0);
        queue_window(0, 0, 255, 0, 0, 0, 0, 0);
        queue_window(0, 0, 0, 1, 0, 0, 0, 0);
        queue_window(0, 0, 0, 0, 1, 0, 0, 0);
        queue_window(0, 0, 0, 0, 0, 0, 1, 0);
        queue_window(0, 1, 0, 0, 0, 0, 0, 0);
        queue_window(255, 0, 0, 255, 0, 248, 2, 0);
        queue_window(255, 0, 0, 255, 0, 252, 1, 0);
        queue_window(0, 0, 3, 1, 0, 255, 255, 255);
        queue_window(10, 20, 10, 30, 30, 10, 20, 10);
        queue_window(255, 0, 255, 0, 255, 0, 255, 0);
        queue_window(0, 255, 0, 255, 0, 255, 0, 255);

        // Random windows: uniform noise, near-flat texture, oriented steps,
        // sparse spikes and symmetric windows with no gradient.
        for (int i = 0; i < RANDOM_WINDOWS; i++)
        begin
            kind = $urandom_range(0, 9);
            lo = $urandom_range(0, 255);
            hi = $urandom_range(0, 255);
            mid = $urandom_range(0, 255);
            dx = int'($urandom_range(0, 2)) - 1;
            dy = int'($urandom_range(0, 2)) - 1;
            for (int j = 0; j < 8; j++)
            begin
                pos = (j < 4) ? j : j + 1;
                if (kind <= 3)
                begin
                    px[j] = $urandom_range(0, 255);
                end
                else if (kind <= 5)
                begin
                    px[j] = (mid % 252) + 2 + int'($urandom_range(0, 4)) - 2;
                end
                else if (kind <= 7)
                begin
                    if (dx * (pos % 3 - 1) + dy * (pos / 3 - 1) > 0)
                    begin
                        px[j] = hi;
                    end
                    else if (dx * (pos % 3 - 1) + dy * (pos / 3 - 1) == 0)
                    begin
                        px[j] = mid;
                    end
                    else
                    begin
                        px[j] = lo;
                    end
                end
                else if (kind == 8)
                begin
                    px[j] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
                end
                else
                begin
                    // Corners, edge centers and side centers each share a value.
                    px[j] = (pos % 2 == 0) ? lo : ((pos == 1 || pos == 7) ? hi : mid);
                end
            end
            queue_window(px[0], px[1], px[2], px[3], px[4], px[5], px[6], px[7]);
        end
        total_windows = pending_windows.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (windows_sent < total_windows || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);

        $display("Checked %0d windows: %0d with a defined direction, %0d flat.",
                 results_seen, directed_seen, flat_seen);
        $display("Directions reached quadrant mask %b; output held once for %0d cycles.",
                 quadrants_hit, LONG_HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("[scharr_gradient_angle_unit] OK");
        end
        else
        begin
            $display("[scharr_gradient_angle_unit] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("[scharr_gradient_angle_unit] ERROR");
        $finish;
    end

endmodule
